/* rtl/core/wtosc_pkg.sv */
package wtosc_pkg;

  // Field and datapath widths.
  localparam int IDX_W       = 7;
  localparam int FRAC_W      = 16;
  localparam int PHASE_W     = IDX_W + FRAC_W;
  localparam int TABLE_DEPTH = 1 << IDX_W;
  localparam int SAMPLE_W    = 16;
  localparam int AMP_W       = 16;
  localparam int CFG_W       = PHASE_W;

  // Shared serial multiplier: signed multiplicand times unsigned multiplier.
  localparam int MCAND_W  = SAMPLE_W + 1;
  localparam int MPLIER_W = 16;
  localparam int PROD_W   = MCAND_W + MPLIER_W;

  // Register indexes of the configuration port.
  localparam logic CFG_PHASE_STEP = 1'b0;
  localparam logic CFG_AMPLITUDE  = 1'b1;

  // Values after reset.
  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 23'd83696;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RESET  = 16'd16384;

  // Sequencer states for one sample.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_DIFF,
    ST_MUL1,
    ST_INTERP,
    ST_MUL2,
    ST_SCALE
  } state_t;

endpackage

/* rtl/core/wtosc_mul.sv */
module wtosc_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [wtosc_pkg::MCAND_W-1:0] mcand,
  input  logic        [wtosc_pkg::MPLIER_W-1:0] mplier,
  output logic                                 done,
  output logic signed [wtosc_pkg::PROD_W-1:0]  product
);

  localparam int UP_W  = wtosc_pkg::MCAND_W + 1;
  localparam int ACC_W = UP_W + wtosc_pkg::MPLIER_W;
  localparam int CNT_W = $clog2(wtosc_pkg::MPLIER_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wtosc_pkg::MPLIER_W - 1);

  logic signed [wtosc_pkg::MCAND_W-1:0] mcand_r;
  logic [ACC_W-1:0]                     acc;
  logic [CNT_W-1:0]                     cnt;
  logic                                 busy;
  logic signed [UP_W-1:0]               upper_sum;

  // One multiplier bit per cycle: add the multiplicand into the upper half
  // when the low bit is set, then shift the whole accumulator right.
  always_comb begin
    upper_sum = $signed(acc[ACC_W-1:wtosc_pkg::MPLIER_W]);
    if (acc[0]) begin
      upper_sum = upper_sum + UP_W'(mcand_r);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      acc     <= {{UP_W{1'b0}}, mplier};
    end else if (busy) begin
      acc <= {upper_sum[UP_W-1], upper_sum, acc[wtosc_pkg::MPLIER_W-1:1]};
    end
  end

  // Bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign product = $signed(acc[wtosc_pkg::PROD_W-1:0]);

endmodule

/* rtl/core/wavetable_oscillator_interp.sv */
// Channel  Handshake           Beat contents
// -------  ------------------  ------------------------------------------
// in       in_valid/in_stall   func, entry_index, entry_value
// out      out_valid/out_stall sample
// cfg      cfg_write           cfg_index, cfg_data (phase_step, amplitude)
//
// A table write beat is taken whenever the sequencer is idle. Once a sample
// beat is taken, no new beat is taken until its sample is loaded: two table
// reads, the difference setup, a multiplier pass (all multiplier bits shifted,
// then done), the blend setup, a second such pass and the output load. The
// sample is valid once loaded; an output stall holds back that load.
// Synchronous reset clears the phase and restores the register defaults;
// the table holds nothing defined until written.
// A finished sample waits in the output register while a new beat is taken;
// the sequencer holds in its last state while the output is still stalled.
module wavetable_oscillator_interp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  func,
  input  logic        [wtosc_pkg::IDX_W-1:0]    entry_index,
  input  logic signed [wtosc_pkg::SAMPLE_W-1:0] entry_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  cfg_write,
  input  logic                                  cfg_index,
  input  logic        [wtosc_pkg::CFG_W-1:0]    cfg_data
);

  localparam int SW = wtosc_pkg::SAMPLE_W;
  localparam int PW = wtosc_pkg::PROD_W;
  localparam int MW = wtosc_pkg::MCAND_W;
  localparam int FW = wtosc_pkg::FRAC_W;

  wtosc_pkg::state_t state, state_next;

  logic [wtosc_pkg::PHASE_W-1:0] phase;
  logic [wtosc_pkg::PHASE_W-1:0] phase_step;
  logic [wtosc_pkg::AMP_W-1:0]   amplitude;

  logic signed [SW-1:0] mem [wtosc_pkg::TABLE_DEPTH];
  logic signed [SW-1:0] rdata;
  logic signed [SW-1:0] v0;
  logic [wtosc_pkg::IDX_W-1:0] idx0;
  logic [wtosc_pkg::IDX_W-1:0] rd_addr;

  logic                           accept;
  logic                           mul_start;
  logic signed [MW-1:0]           mul_mcand;
  logic [wtosc_pkg::MPLIER_W-1:0] mul_mplier;
  logic                           mul_done;
  logic signed [PW-1:0]           product;
  logic                           load_out;

  logic signed [PW:0]   interp_rnd;
  logic signed [MW-1:0] interp_sum;
  logic signed [PW:0]   scale_rnd;
  logic signed [PW-15:0] scale_shr;
  logic signed [SW-1:0] scaled;

  assign in_stall = (state != wtosc_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx0     = phase[wtosc_pkg::PHASE_W-1:FW];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= wtosc_pkg::PHASE_STEP_RESET;
      amplitude  <= wtosc_pkg::AMPLITUDE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        wtosc_pkg::CFG_PHASE_STEP: phase_step <= cfg_data;
        wtosc_pkg::CFG_AMPLITUDE:  amplitude  <= cfg_data[wtosc_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Wave table: one write port, one registered read port.
  assign rd_addr = (state == wtosc_pkg::ST_RD1) ? idx0 + 1'b1 : idx0;

  always_ff @(posedge clk) begin
    if (accept && !func) begin
      mem[entry_index] <= entry_value;
    end
    rdata <= mem[rd_addr];
  end

  // Left entry is held while the right one is read.
  always_ff @(posedge clk) begin
    if (state == wtosc_pkg::ST_RD1) begin
      v0 <= rdata;
    end
  end

  // Rounding of the interpolation product and the linear blend.
  assign interp_rnd = $signed({product[PW-1], product}) + (PW+1)'(1 << (FW - 1));
  assign interp_sum = $signed(interp_rnd[PW-1:FW]) + MW'(v0);

  // Rounding and saturation of the scaled sample.
  assign scale_rnd = $signed({product[PW-1], product}) + (PW+1)'(1 << 14);
  assign scale_shr = scale_rnd[PW:15];

  always_comb begin
    if (scale_shr > $signed((PW-14)'(32767))) begin
      scaled = 16'sh7FFF;
    end else if (scale_shr < $signed(-(PW-14)'(32768))) begin
      scaled = 16'sh8000;
    end else begin
      scaled = scale_shr[SW-1:0];
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtosc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier control.
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_mcand  = $signed({rdata[SW-1], rdata}) - $signed({v0[SW-1], v0});
    mul_mplier = phase[FW-1:0];
    load_out   = 1'b0;
    case (state)
      wtosc_pkg::ST_IDLE: begin
        if (accept && func) begin
          state_next = wtosc_pkg::ST_RD0;
        end
      end
      wtosc_pkg::ST_RD0: state_next = wtosc_pkg::ST_RD1;
      wtosc_pkg::ST_RD1: state_next = wtosc_pkg::ST_DIFF;
      wtosc_pkg::ST_DIFF: begin
        mul_start  = 1'b1;
        state_next = wtosc_pkg::ST_MUL1;
      end
      wtosc_pkg::ST_MUL1: begin
        if (mul_done) begin
          state_next = wtosc_pkg::ST_INTERP;
        end
      end
      wtosc_pkg::ST_INTERP: begin
        mul_start  = 1'b1;
        mul_mcand  = interp_sum;
        mul_mplier = amplitude;
        state_next = wtosc_pkg::ST_MUL2;
      end
      wtosc_pkg::ST_MUL2: begin
        if (mul_done) begin
          state_next = wtosc_pkg::ST_SCALE;
        end
      end
      wtosc_pkg::ST_SCALE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = wtosc_pkg::ST_IDLE;
        end
      end
      default: state_next = wtosc_pkg::ST_IDLE;
    endcase
  end

  // Phase accumulator advances once per produced sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (load_out) begin
      phase <= phase + phase_step;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample <= scaled;
    end
  end

  wtosc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (product)
  );

endmodule
